@@ rtl/rotation_matrix_to_quaternion_top_macros.svh @@
// Assertion macros shared by the RTL of the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RMQ_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RMQ_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq next-cycle check failed");

`endif

@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

  localparam int DW = 16;
  localparam int FB = 14;

  // Stage map: one front stage, eight root stages, one divider setup stage,
  // nine divider stages and the output formatting stage.
  localparam int SQ_FIRST  = 1;
  localparam int SQ_STEPS  = 8;
  localparam int DV_SETUP  = SQ_FIRST + SQ_STEPS;
  localparam int DV_FIRST  = DV_SETUP + 1;
  localparam int DV_STEPS  = 9;
  localparam int OUT_STAGE = DV_FIRST + DV_STEPS;
  localparam int NST       = OUT_STAGE + 1;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam logic [1:0] SLOT_X = 2'd0;
  localparam logic [1:0] SLOT_Y = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;
  localparam logic [1:0] SLOT_W = 2'd3;

  typedef struct packed {
    logic [3:0][17:0] d;      // signed difference or sum for each slot
    logic [1:0]       lead;
    logic [1:0]       branch;
    logic [31:0]      x;      // radicand scaled by 2^FB
    logic [15:0]      root;
    logic [19:0]      srem;
    logic             degen;
    logic [16:0]      dvsr;
    logic [3:0][35:0] rem;
    logic [3:0][17:0] quo;
    logic [3:0]       ovf;
    logic [3:0]       neg;
    logic [3:0][15:0] q;
  } stage_t;

endpackage

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix to unit quaternion, signed Q1.14 in and out.
//
// Input channel: in_valid/in_ready carry one word of nine matrix elements
// (in_m00 .. in_m22). Result channel: out_valid/out_ready carry one word of
// out_qx, out_qy, out_qz, out_qw, out_branch_taken and out_degenerate.
//
// The datapath is a 20-stage pipeline: one stage forms the trace, picks the
// branch and builds the radicand and the off-diagonal terms, eight stages
// take the integer square root two bits at a time, one stage sets up the
// three divisions, nine stages run the restoring dividers two quotient bits
// at a time, and the last stage saturates and drives the result registers.
// An accepted word reaches the result ports after passing every stage, and
// a new word can be accepted every cycle while the pipeline is not frozen.
//
// When the receiver holds out_ready low while a result is waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated. Empty
// slots stay where they are during a stall, so bubbles are not squeezed out.
// Reset clears all stage valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_m00,
  input  logic [15:0] in_m01,
  input  logic [15:0] in_m02,
  input  logic [15:0] in_m10,
  input  logic [15:0] in_m11,
  input  logic [15:0] in_m12,
  input  logic [15:0] in_m20,
  input  logic [15:0] in_m21,
  input  logic [15:0] in_m22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_qx,
  output logic [15:0] out_qy,
  output logic [15:0] out_qz,
  output logic [15:0] out_qw,
  output logic [1:0]  out_branch_taken,
  output logic        out_degenerate
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_top_macros.svh"

  stage_t           st_r [NST];
  stage_t           st_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   vld_nxt;
  logic             adv;
  stage_t           s0;

  // The pipeline moves as one: it advances unless a finished result waits.
  assign adv      = !vld_r[NST-1] || out_ready;
  assign in_ready = adv;

  // Front stage: trace test, branch choice, radicand and the three terms.
  always_comb begin
    logic signed [17:0] a00, a11, a22, a01, a02, a10, a12, a20, a21;
    logic signed [17:0] tr;
    logic signed [18:0] rr;
    logic signed [17:0] dii, djj, dkk;
    logic [1:0]         ib;
    s0 = '0;
    a00 = 18'($signed(in_m00));
    a01 = 18'($signed(in_m01));
    a02 = 18'($signed(in_m02));
    a10 = 18'($signed(in_m10));
    a11 = 18'($signed(in_m11));
    a12 = 18'($signed(in_m12));
    a20 = 18'($signed(in_m20));
    a21 = 18'($signed(in_m21));
    a22 = 18'($signed(in_m22));
    tr  = a00 + a11 + a22;
    ib  = BR_X;
    if (a11 > a00) ib = BR_Y;
    if (a22 > ((ib == BR_Y) ? a11 : a00)) ib = BR_Z;
    dii = a00;
    djj = a11;
    dkk = a22;
    if (tr > 18'sd0) begin
      s0.branch   = BR_TRACE;
      s0.lead     = SLOT_W;
      rr          = 19'(tr) + 19'sd16384;
      s0.d[SLOT_X] = a21 - a12;
      s0.d[SLOT_Y] = a02 - a20;
      s0.d[SLOT_Z] = a10 - a01;
    end else begin
      s0.branch = ib;
      unique case (ib)
        BR_Y: begin
          dii = a11; djj = a22; dkk = a00;
          s0.lead      = SLOT_Y;
          s0.d[SLOT_W] = a02 - a20;
          s0.d[SLOT_Z] = a21 + a12;
          s0.d[SLOT_X] = a01 + a10;
        end
        BR_Z: begin
          dii = a22; djj = a00; dkk = a11;
          s0.lead      = SLOT_Z;
          s0.d[SLOT_W] = a10 - a01;
          s0.d[SLOT_X] = a02 + a20;
          s0.d[SLOT_Y] = a12 + a21;
        end
        default: begin
          s0.lead      = SLOT_X;
          s0.d[SLOT_W] = a21 - a12;
          s0.d[SLOT_Y] = a10 + a01;
          s0.d[SLOT_Z] = a20 + a02;
        end
      endcase
      rr = 19'(dii) - (19'(djj) + 19'(dkk)) + 19'sd16384;
    end
    // A negative radicand is clamped to zero; the rest fits in 17 bits.
    if (rr < 19'sd0) rr = '0;
    s0.x = {rr[16:0], 15'b0} >> 1;
  end

  always_comb begin
    logic [19:0] rem2;
    logic [19:0] trial;
    logic [35:0] numr;
    logic [35:0] dsh;
    logic [16:0] mag;
    logic [18:0] qm;
    logic [31:0] xs;
    int          pr;
    int          bb;
    for (int n = 0; n < NST; n++) begin
      st_nxt[n] = (n == 0) ? s0 : st_r[(n == 0) ? 0 : n - 1];
      if (n >= SQ_FIRST && n < SQ_FIRST + SQ_STEPS) begin
        // Two root bits per stage, most significant pair first.
        for (int h = 0; h < 2; h++) begin
          pr    = 15 - 2 * (n - SQ_FIRST) - h;
          xs    = st_nxt[n].x >> (2 * pr);
          rem2  = {st_nxt[n].srem[17:0], xs[1:0]};
          trial = {2'b0, st_nxt[n].root, 2'b01};
          if (rem2 >= trial) begin
            st_nxt[n].srem = rem2 - trial;
            st_nxt[n].root = {st_nxt[n].root[14:0], 1'b1};
          end else begin
            st_nxt[n].srem = rem2;
            st_nxt[n].root = {st_nxt[n].root[14:0], 1'b0};
          end
        end
      end else if (n == DV_SETUP) begin
        st_nxt[n].degen = (st_nxt[n].root == '0);
        st_nxt[n].dvsr  = {st_nxt[n].root, 1'b0};
        for (int sl = 0; sl < 4; sl++) begin
          st_nxt[n].neg[sl] = st_nxt[n].d[sl][17];
          mag  = st_nxt[n].d[sl][17] ? 17'(-st_nxt[n].d[sl]) : st_nxt[n].d[sl][16:0];
          numr = {5'b0, mag, 14'b0} + {20'b0, st_nxt[n].root};
          st_nxt[n].rem[sl] = numr;
          st_nxt[n].quo[sl] = '0;
          st_nxt[n].ovf[sl] = (numr >= ({19'b0, st_nxt[n].dvsr} << 18));
        end
      end else if (n >= DV_FIRST && n < DV_FIRST + DV_STEPS) begin
        // Two quotient bits per stage for every slot.
        for (int sl = 0; sl < 4; sl++) begin
          for (int h = 0; h < 2; h++) begin
            bb  = 17 - 2 * (n - DV_FIRST) - h;
            dsh = {19'b0, st_nxt[n].dvsr} << bb;
            if (st_nxt[n].rem[sl] >= dsh) begin
              st_nxt[n].rem[sl]     = st_nxt[n].rem[sl] - dsh;
              st_nxt[n].quo[sl][bb] = 1'b1;
            end
          end
        end
      end else if (n == OUT_STAGE) begin
        for (int sl = 0; sl < 4; sl++) begin
          qm = st_nxt[n].ovf[sl] ? '1 : {1'b0, st_nxt[n].quo[sl]};
          if (st_nxt[n].degen) begin
            st_nxt[n].q[sl] = '0;
          end else if (st_nxt[n].lead == 2'(sl)) begin
            st_nxt[n].q[sl] = {1'b0, st_nxt[n].root[15:1]};
          end else if (!st_nxt[n].neg[sl]) begin
            st_nxt[n].q[sl] = (qm > 19'd32767) ? 16'h7fff : qm[15:0];
          end else begin
            st_nxt[n].q[sl] = (qm > 19'd32768) ? 16'h8000 : 16'(-qm[15:0]);
          end
        end
      end
    end
    vld_nxt = {vld_r[NST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < NST; n++) st_r[n] <= st_nxt[n];
    end
  end

  assign out_valid        = vld_r[NST-1];
  assign out_qx           = st_r[NST-1].q[SLOT_X];
  assign out_qy           = st_r[NST-1].q[SLOT_Y];
  assign out_qz           = st_r[NST-1].q[SLOT_Z];
  assign out_qw           = st_r[NST-1].q[SLOT_W];
  assign out_branch_taken = st_r[NST-1].branch;
  assign out_degenerate   = st_r[NST-1].degen;

  `RMQ_CHECK_NOW(a_degen_zero, out_valid && out_degenerate,
    out_qx == '0 && out_qy == '0 && out_qz == '0 && out_qw == '0)
  `RMQ_CHECK_NOW(a_trace_root, out_valid && out_branch_taken == BR_TRACE, !out_degenerate)
  `RMQ_CHECK_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)
  `RMQ_CHECK_NEXT(a_enter, in_valid && in_ready, vld_r[0])

endmodule

@@ test/testbench.sv @@
module testbench;
  import rmq_pkg::*;

  // One matrix word as it goes into the block.
  typedef struct {
    logic signed [15:0] m [3][3];
  } matrix_t;

  // One quaternion word as it comes out of the block.
  typedef struct {
    logic [15:0] qx, qy, qz, qw;
    logic [1:0]  branch;
    logic        degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_m00 = '0, in_m01 = '0, in_m02 = '0;
  logic [15:0] in_m10 = '0, in_m11 = '0, in_m12 = '0;
  logic [15:0] in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_qx, out_qy, out_qz, out_qw;
  logic [1:0] out_branch_taken;
  logic out_degenerate;

  rotation_matrix_to_quaternion_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  matrix_t pending_words[$];
  quat_t   expected_quats[$];
  int      mismatch_count = 0;
  bit      stimulus_done = 1'b0;
  // The sender holds off when this is set, until the expected queue drains.
  bit      drain_request = 1'b0;

  // Floor square root of a non-negative 64-bit value, bit by bit.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // d / (2*s) in Q1.14, rounded to nearest with ties away from zero.
  function automatic longint half_quotient(longint d, longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << FB) + s) / (2 * s);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] saturate16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Shoemake conversion: the trace path when the trace is positive, otherwise
  // the largest diagonal element leads (ties keep the lower index).
  function automatic quat_t shoemake_quat(matrix_t w);
    longint m [3][3];
    longint q [4];
    longint r;
    longint unsigned s;
    int i, j, k;
    quat_t res;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) m[a][b] = w.m[a][b];
    q = '{0, 0, 0, 0};
    if (m[0][0] + m[1][1] + m[2][2] > 0) begin
      res.branch = BR_TRACE;
      r = m[0][0] + m[1][1] + m[2][2] + (64'd1 << FB);
      s = root_floor(r << FB);
      q[3] = s >> 1;
      q[0] = half_quotient(m[2][1] - m[1][2], s);
      q[1] = half_quotient(m[0][2] - m[2][0], s);
      q[2] = half_quotient(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      res.branch = 2'(i + 1);
      r = m[i][i] - (m[j][j] + m[k][k]) + (64'd1 << FB);
      if (r < 0) r = 0;
      s = root_floor(r << FB);
      if (s != 0) begin
        q[i] = s >> 1;
        q[3] = half_quotient(m[k][j] - m[j][k], s);
        q[j] = half_quotient(m[j][i] + m[i][j], s);
        q[k] = half_quotient(m[k][i] + m[i][k], s);
      end
    end
    res.qx = saturate16(q[0]);
    res.qy = saturate16(q[1]);
    res.qz = saturate16(q[2]);
    res.qw = saturate16(q[3]);
    res.degen = (s == 0);
    return res;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t w;
    int mode;
    mode = $urandom_range(0, 3);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        case (mode)
          0: w.m[a][b] = 16'($urandom);                             // full range
          1: w.m[a][b] = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
          2: w.m[a][b] = (a == b) ? 16'($urandom_range(0, 8)) - 16'sd4
                                  : 16'($urandom);                  // near-zero diagonal
          default: w.m[a][b] = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
        endcase
      end
    return w;
  endfunction

  function automatic matrix_t diag_matrix(int a, int b, int c, int off);
    matrix_t w;
    for (int r = 0; r < 3; r++)
      for (int q = 0; q < 3; q++) w.m[r][q] = 16'(off * (r * 3 + q + 1));
    w.m[0][0] = 16'(a);
    w.m[1][1] = 16'(b);
    w.m[2][2] = 16'(c);
    return w;
  endfunction

  // The directed words cover the identity, the three half-turns (one per
  // leading axis), ties on the diagonal, saturation and the field extremes;
  // random words follow.
  initial begin
    matrix_t w;
    pending_words.push_back(diag_matrix(16384, 16384, 16384, 0));
    pending_words.push_back(diag_matrix(16384, -16384, -16384, 0));
    pending_words.push_back(diag_matrix(-16384, 16384, -16384, 0));
    pending_words.push_back(diag_matrix(-16384, -16384, 16384, 0));
    pending_words.push_back(diag_matrix(0, 0, 0, 100));
    pending_words.push_back(diag_matrix(-5, -5, -5, 7));
    pending_words.push_back(diag_matrix(-32768, -32768, -32768, 1));
    pending_words.push_back(diag_matrix(32767, 32767, 32767, 3000));
    pending_words.push_back(diag_matrix(1, 0, 0, 0));
    pending_words.push_back(diag_matrix(-32768, 32767, 32767, 0));
    pending_words.push_back(diag_matrix(0, -16384, -16384, 1000));
    pending_words.push_back(diag_matrix(-100, -100, -200, -3000));
    for (int v = 0; v < 4; v++) begin
      for (int r = 0; r < 3; r++)
        for (int q = 0; q < 3; q++)
          case (v)
            0: w.m[r][q] = 16'h7fff;
            1: w.m[r][q] = 16'h8000;
            2: w.m[r][q] = (r == q) ? 16'sh8000 : 16'sh7fff;
            default: w.m[r][q] = (r == q) ? 16'sh7fff : 16'sh8000;
          endcase
      pending_words.push_back(w);
    end
    for (int n = 0; n < 1050; n++) pending_words.push_back(random_matrix());
  end

  int send_gap = 0;
  int sent_count = 0;

  task automatic w_drive(matrix_t w);
    in_m00 <= w.m[0][0]; in_m01 <= w.m[0][1]; in_m02 <= w.m[0][2];
    in_m10 <= w.m[1][0]; in_m11 <= w.m[1][1]; in_m12 <= w.m[1][2];
    in_m20 <= w.m[2][0]; in_m21 <= w.m[2][1]; in_m22 <= w.m[2][2];
  endtask

  // Sender: one word per handshake, with a random gap before each word.
  // A gap of zero puts the next word out right behind the one just taken.
  always @(posedge clk) begin
    int gap;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_quats.push_back(shoemake_quat(pending_words.pop_front()));
        sent_count <= sent_count + 1;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (sent_count == 500) drain_request <= 1'b1;
        if (gap == 0 && sent_count != 500 && pending_words.size() > 0) begin
          w_drive(pending_words[0]);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          send_gap <= gap;
        end
      end else if (!in_valid) begin
        if (drain_request) begin
          if (expected_quats.size() == 0) drain_request <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_words.size() > 0) begin
          w_drive(pending_words[0]);
          in_valid <= 1'b1;
        end else begin
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  int stall_left = 0;

  // Receiver: out_ready drops for a random stretch after each word.
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected quaternion word");
        end else begin
          exp_q = expected_quats.pop_front();
          if (out_qx !== exp_q.qx || out_qy !== exp_q.qy || out_qz !== exp_q.qz ||
              out_qw !== exp_q.qw || out_branch_taken !== exp_q.branch ||
              out_degenerate !== exp_q.degen) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %h %h %h %h br %0d dg %0b, got %h %h %h %h br %0d dg %0b",
                       exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.branch, exp_q.degen,
                       out_qx, out_qy, out_qz, out_qw, out_branch_taken, out_degenerate);
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_quats.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_quats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
